// ===== design/shunt_current_average_ema_assert.svh =====
// Assertion macros for the shunt current sense block.
// Included by the top level; needs nothing else.
`ifndef SHUNT_CURRENT_AVERAGE_EMA_ASSERT_SVH
`define SHUNT_CURRENT_AVERAGE_EMA_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SCAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shunt current sense: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SCAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shunt current sense: next-cycle check failed");

`endif

// ===== design/scae_pkg.sv =====
// Shared widths, constants and handshake structs for the shunt current sense block.
// No dependencies; imported by the divider and the top level.
package scae_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 20;
    localparam int AVG_W      = 20;
    localparam int DIFF_W     = 21;
    localparam int MUL_B_W    = 28;
    localparam int PROD_W     = DIFF_W + MUL_B_W;
    localparam int DIVIDEND_W = 28;
    localparam int DIVISOR_W  = 16;
    localparam int COUNT_W    = 5;
    localparam int FILT_W     = 25;
    localparam int CURRENT_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int SCALE_NUM   = 151;
    localparam int SCALE_DEN   = 100;
    localparam int SCALE_SHIFT = 27;
    // Rounded-up fixed-point gain: (a * SCALE_RECIP) >> SCALE_SHIFT equals
    // a * 151 / 100 rounded down for every average below 2^20.
    localparam logic [MUL_B_W-1:0] SCALE_RECIP =
        MUL_B_W'(((64'(SCALE_NUM) << SCALE_SHIFT) + 64'(SCALE_DEN) - 64'd1)
                 / 64'(SCALE_DEN));
    localparam logic [MUL_B_W-1:0] MV_NUM    = 28'd3300;
    localparam int                 MV_SHIFT  = 12;
    localparam int                 EMA_SHIFT = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SHUNT_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUNT_RESISTANCE = 8'd1;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/scae_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on scae_pkg for widths and the request/response structs.
module scae_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scae_pkg::t_div_req i_req,
    output scae_pkg::t_div_rsp o_rsp
);
    import scae_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_work;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    trial;
    logic                  q_bit;
    logic [DIVISOR_W-1:0]  n_rem;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_work[DIVIDEND_W-1]} - {1'b0, r_divisor};
        q_bit = ~trial[DIVISOR_W] | r_rem[DIVISOR_W-1];
        if (q_bit) begin
            n_rem = trial[DIVISOR_W-1:0];
        end else begin
            n_rem = {r_rem[DIVISOR_W-2:0], r_work[DIVIDEND_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_W'(DIVIDEND_W);
                r_work    <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_work <= {r_work[DIVIDEND_W-2:0], q_bit};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work;

endmodule

// ===== design/shunt_current_average_ema.sv =====
// Sequencing: a sample tick only updates the sums and the tick counter; a compute tick
// steps through ST_MUL_SCALE, ST_DIFF, ST_MUL_MV, ST_MUL_CNT, ST_DIV_RES, ST_WAIT_RES and ST_OUT.
// Throughput: one transaction per cycle while accumulating; after a compute tick the
// input stalls until the sequencer is back in ST_ACC, and a compute tick waits for the output register to drain.
// Reset (synchronous, active low) clears the sums, tick counter, filter and output valid;
// shunt_count and shunt_resistance come up as 1.
module shunt_current_average_ema #(
    parameter int SAMPLES_PER_BLOCK = 16,
    parameter int AVERAGE_SHIFT     = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream; tdata from bit 0 up: amp_sample[11:0], ref_sample[23:12].
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,
    // Output stream; tdata from bit 0 up: discharge_current[15:0], charge_current[31:16].
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scae_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scae_pkg::*;

`include "shunt_current_average_ema_assert.svh"

    // The tick counter must hold SAMPLES_PER_BLOCK itself: that value marks the
    // compute tick.
    localparam int TICK_W = $clog2(SAMPLES_PER_BLOCK + 1);

    // Sequencer. ST_ACC is the only state that takes input transactions; the other
    // states step through the shared multiplier, the comparison and the divider.
    typedef enum logic [3:0] {
        ST_ACC,
        ST_MUL_SCALE,
        ST_DIFF,
        ST_MUL_MV,
        ST_MUL_CNT,
        ST_DIV_RES,
        ST_WAIT_RES,
        ST_OUT
    } t_state;

    t_state                r_state;
    t_state                n_state;

    logic [TICK_W-1:0]     r_tick;
    logic [SUM_W-1:0]      r_amp_sum;
    logic [SUM_W-1:0]      r_ref_sum;
    logic [AVG_W-1:0]      r_amp_avg;
    logic [AVG_W-1:0]      r_ref_avg;
    logic [PROD_W-1:0]     r_prod;
    logic [DIFF_W-1:0]     r_diff;
    logic                  r_disch;
    logic [FILT_W-1:0]     r_filter;
    logic                  r_out_valid;
    logic [31:0]           r_out_data;
    logic [COUNT_W-1:0]    r_shunt_count;
    logic [DIVISOR_W-1:0]  r_shunt_res;

    logic [SAMPLE_W-1:0]   amp_sample;
    logic [SAMPLE_W-1:0]   ref_sample;
    logic                  in_fire;
    logic                  compute_tick;
    logic                  cfg_fire;

    logic [DIFF_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;

    t_div_req              div_req;
    t_div_rsp              div_rsp;

    logic [DIFF_W-1:0]     amp_scaled;
    logic                  disch;
    logic [DIFF_W-1:0]     diff;
    logic [FILT_W-1:0]     ema_in;
    logic signed [FILT_W:0] ema_delta;
    logic signed [FILT_W:0] ema_sum;
    logic [CURRENT_W-1:0]  current_sat;

    assign amp_sample   = s_axis_tdata[SAMPLE_W-1:0];
    assign ref_sample   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign compute_tick = (r_tick == TICK_W'(SAMPLES_PER_BLOCK));

    // A plain sample tick only touches the sums, so it is taken even while a
    // result waits downstream. A compute tick needs the output register free.
    assign s_axis_tready = (r_state == ST_ACC) && (!compute_tick || !r_out_valid);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // Shared multiplier. Its operands follow the sequencer state and the product
    // is always registered into r_prod before anything else uses it. The gain of
    // 151/100 is applied as a multiplication by its fixed-point value, SCALE_RECIP.
    always_comb begin
        case (r_state)
            ST_MUL_SCALE: begin
                mul_a = DIFF_W'(r_amp_avg);
                mul_b = SCALE_RECIP;
            end
            ST_MUL_MV: begin
                mul_a = r_diff;
                mul_b = MV_NUM;
            end
            ST_MUL_CNT: begin
                mul_a = r_prod[MV_SHIFT +: DIFF_W];
                mul_b = MUL_B_W'(r_shunt_count);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Divider, by the sense resistance. A resistance of zero divides as one.
    always_comb begin
        div_req.start    = (r_state == ST_DIV_RES);
        div_req.dividend = r_prod[DIVIDEND_W-1:0];
        if (r_shunt_res == '0) begin
            div_req.divisor = DIVISOR_W'(1);
        end else begin
            div_req.divisor = r_shunt_res;
        end
    end

    scae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Direction and magnitude once the scaled amplifier average is known.
    // Equal averages count as charging.
    always_comb begin
        amp_scaled = r_prod[SCALE_SHIFT +: DIFF_W];
        disch      = DIFF_W'(r_ref_avg) > amp_scaled;
        if (disch) begin
            diff = DIFF_W'(r_ref_avg) - amp_scaled;
        end else begin
            diff = amp_scaled - DIFF_W'(r_ref_avg);
        end
    end

    // Exponential filter, weight 1/8. The arithmetic shift of the signed
    // difference rounds toward minus infinity, as the filter requires. The
    // filter only moves toward its input, so it never goes negative.
    always_comb begin
        ema_in    = div_rsp.quotient[FILT_W:1];
        ema_delta = $signed({1'b0, ema_in}) - $signed({1'b0, r_filter});
        ema_sum   = $signed({1'b0, r_filter}) + (ema_delta >>> EMA_SHIFT);
    end

    // The output field saturates; the filter state keeps its full width.
    assign current_sat = (|r_filter[FILT_W-1:CURRENT_W]) ? {CURRENT_W{1'b1}}
                                                         : r_filter[CURRENT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (in_fire && compute_tick) begin
                    n_state = ST_MUL_SCALE;
                end
            end
            ST_MUL_SCALE:  n_state = ST_DIFF;
            ST_DIFF:       n_state = ST_MUL_MV;
            ST_MUL_MV:     n_state = ST_MUL_CNT;
            ST_MUL_CNT:    n_state = ST_DIV_RES;
            ST_DIV_RES:    n_state = ST_WAIT_RES;
            ST_WAIT_RES: begin
                if (div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:        n_state = ST_ACC;
            default:       n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_ACC;
            r_tick        <= '0;
            r_amp_sum     <= '0;
            r_ref_sum     <= '0;
            r_filter      <= '0;
            r_out_valid   <= 1'b0;
            r_shunt_count <= COUNT_W'(1);
            r_shunt_res   <= DIVISOR_W'(1);
        end else begin
            r_state <= n_state;

            if (cfg_fire) begin
                if (i_cfg_index == REG_SHUNT_COUNT) begin
                    r_shunt_count <= i_cfg_data[COUNT_W-1:0];
                end else if (i_cfg_index == REG_SHUNT_RESISTANCE) begin
                    r_shunt_res <= i_cfg_data[DIVISOR_W-1:0];
                end
            end

            // Accumulate, or on the compute tick drop the samples, capture the
            // averages and restart the block.
            if (in_fire) begin
                if (compute_tick) begin
                    r_amp_avg <= AVG_W'(r_amp_sum >> AVERAGE_SHIFT);
                    r_ref_avg <= AVG_W'(r_ref_sum >> AVERAGE_SHIFT);
                    r_tick    <= '0;
                    r_amp_sum <= '0;
                    r_ref_sum <= '0;
                end else begin
                    r_tick    <= r_tick + 1'b1;
                    r_amp_sum <= r_amp_sum + SUM_W'(amp_sample);
                    r_ref_sum <= r_ref_sum + SUM_W'(ref_sample);
                end
            end

            if (r_state == ST_MUL_SCALE || r_state == ST_MUL_MV ||
                r_state == ST_MUL_CNT) begin
                r_prod <= mul_p;
            end

            if (r_state == ST_DIFF) begin
                r_diff  <= diff;
                r_disch <= disch;
            end

            if (r_state == ST_WAIT_RES && div_rsp.done) begin
                r_filter <= ema_sum[FILT_W-1:0];
            end

            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_OUT) begin
                r_out_valid <= 1'b1;
                if (r_disch) begin
                    r_out_data <= {{CURRENT_W{1'b0}}, current_sat};
                end else begin
                    r_out_data <= {current_sat, {CURRENT_W{1'b0}}};
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Input is only taken while the sequencer is idle.
    `SCAE_ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, r_state != ST_ACC, !s_axis_tready)
    // A compute tick never lands on an occupied output register.
    `SCAE_ASSERT_IMP(a_out_free, i_clk, i_rst_n, in_fire && compute_tick, !r_out_valid)
    // The divider only finishes while the sequencer waits for it.
    `SCAE_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, div_rsp.done, r_state == ST_WAIT_RES)
    // Only one of the two current fields is ever nonzero.
    `SCAE_ASSERT_IMP(a_one_direction, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[15:0] == 16'd0 || m_axis_tdata[31:16] == 16'd0)
    // Each divider start leads to a busy divider on the next cycle.
    `SCAE_ASSERT_NXT(a_div_starts, i_clk, i_rst_n, div_req.start, div_rsp.busy)

endmodule
